/* rtl/core/cc20_pkg.sv */
// shared types and constants for the chacha20 stream cipher core
// no dependencies; imported by every module under rtl/core
`default_nettype none

package cc20_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_DBL   = 10;
  localparam int unsigned BLK_BYTES = 64;
  localparam int unsigned POS_W     = $clog2(BLK_BYTES);
  localparam int unsigned DBL_W     = $clog2(NUM_DBL);
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [3:0][WORD_W-1:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY01   = 3'd0,
    REG_KEY23   = 3'd1,
    REG_KEY45   = 3'd2,
    REG_KEY67   = 3'd3,
    REG_NONCE01 = 3'd4,
    REG_NONCE2  = 3'd5,
    REG_START   = 3'd6
  } cfg_idx_t;

  // request from the byte stage to the block generator
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] ctr;
  } gen_req_t;

  // status back from the block generator
  typedef struct packed {
    logic busy;
    logic done;
  } gen_sts_t;

endpackage

`default_nettype wire

/* rtl/core/cc20_qr_unit.sv */
// shared quarter-round step: one add, one xor and one fixed rotate per cycle
// depends on cc20_pkg
`default_nettype none

module cc20_qr_unit (
  input  wire logic [cc20_pkg::WORD_W-1:0] x,
  input  wire logic [cc20_pkg::WORD_W-1:0] y,
  input  wire logic [cc20_pkg::WORD_W-1:0] z,
  input  wire logic [1:0]                  step,
  output logic      [cc20_pkg::WORD_W-1:0] sum,
  output logic      [cc20_pkg::WORD_W-1:0] mix
);
  import cc20_pkg::*;

  logic [WORD_W-1:0] t;

  assign sum = x + y;
  assign t   = z ^ sum;

  // rotate amounts 16, 12, 8, 7 for the four steps
  always_comb begin
    case (step)
      2'd0:    mix = {t[15:0], t[31:16]};
      2'd1:    mix = {t[19:0], t[31:20]};
      2'd2:    mix = {t[23:0], t[31:24]};
      2'd3:    mix = {t[24:0], t[31:25]};
      default: mix = t;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/cc20_block_gen.sv */
// keystream block generator: 4x4 word state, sequencer and one shared qr step
// depends on cc20_pkg and cc20_qr_unit
`default_nettype none

module cc20_block_gen (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cc20_pkg::gen_req_t               req,
  input  wire logic [7:0][cc20_pkg::WORD_W-1:0] key,
  input  wire logic [2:0][cc20_pkg::WORD_W-1:0] nonce,
  output cc20_pkg::gen_sts_t                    sts,
  output logic [15:0][cc20_pkg::WORD_W-1:0]     words
);
  import cc20_pkg::*;

  typedef enum logic [2:0] {
    G_IDLE,
    G_RUN,
    G_DIAG,
    G_UNDIAG,
    G_FF
  } gstate_t;

  gstate_t st_r, st_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [1:0]       col_r, col_nxt;
  logic             diag_r, diag_nxt;
  logic [DBL_W-1:0] dbl_r, dbl_nxt;
  logic             done_r, done_nxt;
  logic [WORD_W-1:0] ctr_r, ctr_nxt;

  // rows: a = words 0..3, b = 4..7, c = 8..11, d = 12..15; column 0 is worked on
  logic [3:0][WORD_W-1:0] a_r, b_r, c_r, d_r;
  logic [3:0][WORD_W-1:0] a_nxt, b_nxt, c_nxt, d_nxt;

  logic [WORD_W-1:0] ux, uy, uz, usum, umix;
  logic [WORD_W-1:0] a0, b0, c0, d0;

  cc20_qr_unit u_qr (
    .x    (ux),
    .y    (uy),
    .z    (uz),
    .step (step_r),
    .sum  (usum),
    .mix  (umix)
  );

  always_comb begin
    if (step_r[0]) begin
      ux = c_r[0];
      uy = d_r[0];
      uz = b_r[0];
    end else begin
      ux = a_r[0];
      uy = b_r[0];
      uz = d_r[0];
    end
  end

  always_comb begin
    a0 = a_r[0];
    b0 = b_r[0];
    c0 = c_r[0];
    d0 = d_r[0];
    if (step_r[0]) begin
      c0 = usum;
      b0 = umix;
    end else begin
      a0 = usum;
      d0 = umix;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    col_nxt  = col_r;
    diag_nxt = diag_r;
    dbl_nxt  = dbl_r;
    done_nxt = 1'b0;
    ctr_nxt  = ctr_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    d_nxt    = d_r;
    case (st_r)
      G_IDLE: begin
        if (req.start) begin
          ctr_nxt  = req.ctr;
          a_nxt    = SIGMA;
          b_nxt    = key[3:0];
          c_nxt    = key[7:4];
          d_nxt    = {nonce, req.ctr};
          step_nxt = 2'd0;
          col_nxt  = 2'd0;
          diag_nxt = 1'b0;
          dbl_nxt  = '0;
          st_nxt   = G_RUN;
        end
      end
      G_RUN: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          // quarter round finished: move the next column into place
          a_nxt   = {a0, a_r[3:1]};
          b_nxt   = {b0, b_r[3:1]};
          c_nxt   = {c0, c_r[3:1]};
          d_nxt   = {d0, d_r[3:1]};
          col_nxt = col_r + 2'd1;
          if (col_r == 2'd3) begin
            if (!diag_r) begin
              st_nxt = G_DIAG;
            end else begin
              st_nxt = G_UNDIAG;
            end
          end
        end else begin
          a_nxt[0] = a0;
          b_nxt[0] = b0;
          c_nxt[0] = c0;
          d_nxt[0] = d0;
        end
      end
      G_DIAG: begin
        b_nxt    = {b_r[0],   b_r[3:1]};
        c_nxt    = {c_r[1:0], c_r[3:2]};
        d_nxt    = {d_r[2:0], d_r[3]};
        diag_nxt = 1'b1;
        st_nxt   = G_RUN;
      end
      G_UNDIAG: begin
        b_nxt    = {b_r[2:0], b_r[3]};
        c_nxt    = {c_r[1:0], c_r[3:2]};
        d_nxt    = {d_r[0],   d_r[3:1]};
        diag_nxt = 1'b0;
        dbl_nxt  = dbl_r + 1'b1;
        if (dbl_r == DBL_W'(NUM_DBL - 1)) begin
          st_nxt = G_FF;
        end else begin
          st_nxt = G_RUN;
        end
      end
      G_FF: begin
        // feed-forward of the input block, sixteen independent adds
        for (int i = 0; i < 4; i++) begin
          a_nxt[i] = a_r[i] + SIGMA[i];
          b_nxt[i] = b_r[i] + key[i];
          c_nxt[i] = c_r[i] + key[4+i];
        end
        d_nxt[0] = d_r[0] + ctr_r;
        for (int i = 1; i < 4; i++) begin
          d_nxt[i] = d_r[i] + nonce[i-1];
        end
        done_nxt = 1'b1;
        st_nxt   = G_IDLE;
      end
      default: st_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= G_IDLE;
      step_r <= 2'd0;
      col_r  <= 2'd0;
      diag_r <= 1'b0;
      dbl_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      col_r  <= col_nxt;
      diag_r <= diag_nxt;
      dbl_r  <= dbl_nxt;
      done_r <= done_nxt;
    end
    ctr_r <= ctr_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
  end

  assign sts.busy = (st_r != G_IDLE);
  assign sts.done = done_r;
  assign words    = {d_r, c_r, b_r, a_r};

endmodule

`default_nettype wire

/* rtl/core/chacha20_stream_cipher_core.sv */
// chacha20 stream cipher core: config registers, byte position and counter,
// output register; depends on cc20_pkg and cc20_block_gen
//
//   channel | dir | tdata                  | tuser
//   in_     | in  | [7:0] data_byte        | [0] first_of_message
//   out_    | out | [7:0] out_byte         | -
//   cfg_    | in  | write only, index 0..6 | -
//
// a byte at block position 0 starts a keystream block: a load, 10 double
// rounds of 2 x 16 qr steps plus a diagonal and an undiagonal shuffle, a
// feed-forward and the output; other bytes reach out_tvalid the cycle after accept
// the shared qr step unit (one add, xor, rotate per cycle) sets the block time
// reset clears config, counter and position; the keystream needs no clearing
// in_tready stays low while a block is computed or the output is stalled
`default_nettype none

module chacha20_stream_cipher_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  wire logic                             in_tuser,   // [0] first_of_message
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [7:0]                            out_tdata,  // [7:0] out_byte
  input  wire logic                             cfg_we,
  input  wire logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [cc20_pkg::CFG_W-1:0]       cfg_wdata
);
  import cc20_pkg::*;

  typedef enum logic {
    T_IDLE,
    T_GEN
  } tstate_t;

  tstate_t st_r, st_nxt;

  logic [3:0][CFG_W-1:0] key_r;
  logic [CFG_W-1:0]      nonce01_r;
  logic [WORD_W-1:0]     nonce2_r;
  logic [WORD_W-1:0]     start_r;

  logic [WORD_W-1:0] ctr_r, ctr_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [7:0]        odata_r, odata_nxt;
  logic [7:0]        data_r, data_nxt;

  logic              accept;
  logic [WORD_W-1:0] ctr_eff;
  logic [POS_W-1:0]  pos_eff;
  logic [3:0][7:0]   ks_word;

  gen_req_t                  req;
  gen_sts_t                  sts;
  logic [7:0][WORD_W-1:0]    key_words;
  logic [2:0][WORD_W-1:0]    nonce_words;
  logic [15:0][WORD_W-1:0]   words;

  assign key_words   = key_r;
  assign nonce_words = {nonce2_r, nonce01_r};

  cc20_block_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .key   (key_words),
    .nonce (nonce_words),
    .sts   (sts),
    .words (words)
  );

  assign in_tready = (st_r == T_IDLE) && !sts.busy && (!ovalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign ctr_eff   = in_tuser ? start_r : ctr_r;
  assign pos_eff   = in_tuser ? '0 : pos_r;
  assign ks_word   = words[pos_eff[POS_W-1:2]];

  always_comb begin
    st_nxt     = st_r;
    ctr_nxt    = ctr_r;
    pos_nxt    = pos_r;
    data_nxt   = data_r;
    odata_nxt  = odata_r;
    ovalid_nxt = ovalid_r && !out_tready;
    req.start  = 1'b0;
    req.ctr    = ctr_eff;
    case (st_r)
      T_IDLE: begin
        if (accept) begin
          pos_nxt = pos_eff + 1'b1;
          ctr_nxt = (pos_eff == '1) ? ctr_eff + 1'b1 : ctr_eff;
          if (pos_eff == '0) begin
            req.start = 1'b1;
            data_nxt  = in_tdata;
            st_nxt    = T_GEN;
          end else begin
            odata_nxt  = in_tdata ^ ks_word[pos_eff[1:0]];
            ovalid_nxt = 1'b1;
          end
        end
      end
      T_GEN: begin
        // first byte of a fresh block is byte 0 of word 0
        if (sts.done) begin
          odata_nxt  = data_r ^ words[0][7:0];
          ovalid_nxt = 1'b1;
          st_nxt     = T_IDLE;
        end
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= T_IDLE;
      ctr_r     <= '0;
      pos_r     <= '0;
      ovalid_r  <= 1'b0;
      key_r     <= '0;
      nonce01_r <= '0;
      nonce2_r  <= '0;
      start_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      ctr_r    <= ctr_nxt;
      pos_r    <= pos_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          REG_KEY01:   key_r[0]  <= cfg_wdata;
          REG_KEY23:   key_r[1]  <= cfg_wdata;
          REG_KEY45:   key_r[2]  <= cfg_wdata;
          REG_KEY67:   key_r[3]  <= cfg_wdata;
          REG_NONCE01: nonce01_r <= cfg_wdata;
          REG_NONCE2:  nonce2_r  <= cfg_wdata[WORD_W-1:0];
          REG_START:   start_r   <= cfg_wdata[WORD_W-1:0];
          default: ;
        endcase
      end
    end
    data_r  <= data_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

`default_nettype wire
